[rtl/core/badws_pkg.sv]
// Package for the bus address decoder: region codes, register indexes and field widths.
// Has no dependencies; imported by bus_address_decode_and_wait_states.
package badws_pkg;

	localparam int ADDR_W     = 32;
	localparam int MAPPED_W   = 28;
	localparam int REGION_W   = 4;
	localparam int BYTES_W    = 3;
	localparam int WAIT_W     = 4;
	localparam int ROM_SIZE_W = 26;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = ROM_SIZE_W;

	// Offset into the ROM window; regions 8 to 13 span less than 2^27 bytes.
	localparam int ROM_OFF_W  = 27;

	typedef logic [REGION_W-1:0] region_t;

	localparam region_t REGION_BIOS  = 4'h0;
	localparam region_t REGION_WRAM  = 4'h2;
	localparam region_t REGION_IRAM  = 4'h3;
	localparam region_t REGION_PAL   = 4'h5;
	localparam region_t REGION_VRAM  = 4'h6;
	localparam region_t REGION_OAM   = 4'h7;
	localparam region_t REGION_ROM_LO = 4'h8;
	localparam region_t REGION_ROM_HI = 4'hD;
	localparam region_t REGION_SRAM0 = 4'hE;
	localparam region_t REGION_SRAM1 = 4'hF;

	localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRAM_HALF = 1'b1;

	localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = 26'h2000000;

	localparam logic [MAPPED_W-1:0] WRAM_MASK = 28'h203FFFF;
	localparam logic [MAPPED_W-1:0] IRAM_MASK = 28'h3007FFF;
	localparam logic [MAPPED_W-1:0] PAL_MASK  = 28'h50003FF;
	localparam logic [MAPPED_W-1:0] VRAM_MASK = 28'h601FFFF;
	localparam logic [MAPPED_W-1:0] OAM_MASK  = 28'h70003FF;
	localparam logic [MAPPED_W-1:0] ROM_BASE  = 28'h8000000;

	typedef logic [MAPPED_W-1:0] mapped_t;

endpackage

[rtl/core/bus_address_decode_and_wait_states.sv]
// Top level of the bus address decoder: region decode, mirroring, ROM bound check and
// wait-state lookup in a three-stage pipeline. Depends on badws_pkg.
//
// One bus transaction is accepted on every cycle in which start is high and busy is low, and
// its decoded result appears on the result ports together with done once it has passed the
// three register stages (input capture, mirroring and wait lookup, ROM bound compare); a new
// transaction can enter every cycle in which busy is low. busy is high only in the first cycle
// after reset is released. Results cannot be held off by the receiver. The ROM size and SRAM
// mirror registers must only be written while no transaction is in flight.
module bus_address_decode_and_wait_states
	import badws_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      start,
	output logic                      busy,
	input  logic [ADDR_W-1:0]         address,
	input  logic [BYTES_W-1:0]        access_bytes,
	input  logic                      sequential,
	output logic                      done,
	output logic [REGION_W-1:0]       region,
	output logic [MAPPED_W-1:0]       mapped_address,
	output logic                      rom_out_of_range,
	output logic [WAIT_W-1:0]         wait_cycles
);

	// Configuration registers.
	logic [ROM_SIZE_W-1:0] rom_size_q;
	logic                  sram_half_q;
	logic                  busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_size_q  <= ROM_SIZE_RESET;
			sram_half_q <= 1'b0;
			busy_q      <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					CFG_ROM_SIZE:  rom_size_q  <= cfg_data;
					CFG_SRAM_HALF: sram_half_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	assign busy = busy_q;

	logic accept;
	assign accept = start && !busy_q;

	// ROM mask: size rounded up to a power of two, minus one. A size of zero
	// leaves the offset unmasked.
	logic [ROM_SIZE_W-1:0] size_m1;
	logic [ROM_SIZE_W-1:0] smear;
	logic [ROM_OFF_W-1:0]  rom_mask;
	logic                  size_zero;

	assign size_m1 = rom_size_q - ROM_SIZE_W'(1);

	always_comb begin
		for (int i = 0; i < ROM_SIZE_W; i++) begin
			smear[i] = |(size_m1 >> i);
		end
	end

	assign size_zero = (rom_size_q == '0);
	assign rom_mask  = size_zero ? {ROM_OFF_W{1'b1}} : {1'b0, smear};

	// ---------------------------------------------------------------- stage 1
	logic                  valid_s1;
	logic [MAPPED_W-1:0]   addr_s1;
	region_t               region_s1;
	logic [2:0]            width_s1;
	logic                  seq_s1;
	logic [ROM_OFF_W-1:0]  mask_s1;
	logic [2:0]            width_clamped;

	always_comb begin
		if (access_bytes == 3'd0) begin
			width_clamped = 3'd1;
		end else if (access_bytes > 3'd4) begin
			width_clamped = 3'd4;
		end else begin
			width_clamped = access_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= address[MAPPED_W-1:0];
			region_s1 <= address[MAPPED_W-1:MAPPED_W-REGION_W];
			width_s1  <= width_clamped;
			seq_s1    <= sequential;
			mask_s1   <= rom_mask;
		end
	end

	// ---------------------------------------------------------------- stage 2
	logic                  valid_s2;
	region_t               region_s2;
	mapped_t               mapped_s2;
	logic [ROM_OFF_W-1:0]  off_s2;
	logic                  is_rom_s2;
	logic [WAIT_W-1:0]     wait_s2;

	mapped_t               mapped_d;
	mapped_t               rom_off_full;
	logic [ROM_OFF_W-1:0]  rom_off;
	logic                  is_rom;
	logic                  n_two;
	logic [WAIT_W-1:0]     wait_d;

	assign is_rom       = (region_s1 >= REGION_ROM_LO) && (region_s1 <= REGION_ROM_HI);
	assign n_two        = (width_s1 >= 3'd3);
	assign rom_off_full = addr_s1 - ROM_BASE;
	assign rom_off      = rom_off_full[ROM_OFF_W-1:0] & mask_s1;

	always_comb begin
		mapped_d = addr_s1;
		wait_d   = '0;
		case (region_s1)
			REGION_WRAM: begin
				mapped_d = addr_s1 & WRAM_MASK;
				wait_d   = n_two ? 4'd5 : 4'd2;
			end
			REGION_IRAM: begin
				mapped_d = addr_s1 & IRAM_MASK;
			end
			REGION_PAL: begin
				mapped_d = addr_s1 & PAL_MASK;
			end
			REGION_VRAM: begin
				mapped_d = addr_s1 & VRAM_MASK;
				// The top 32K of the 128K window folds onto the 32K below it.
				if (mapped_d[16] && mapped_d[15]) begin
					mapped_d[15] = 1'b0;
				end
				wait_d = n_two ? 4'd1 : 4'd0;
			end
			REGION_OAM: begin
				mapped_d = addr_s1 & OAM_MASK;
				wait_d   = n_two ? 4'd1 : 4'd0;
			end
			REGION_SRAM0, REGION_SRAM1: begin
				mapped_d = {REGION_SRAM0, 8'h00, addr_s1[15:0]};
				if (sram_half_q && mapped_d[15]) begin
					mapped_d[15] = 1'b0;
				end
				case (width_s1)
					3'd1:    wait_d = 4'd2;
					3'd2:    wait_d = 4'd5;
					3'd3:    wait_d = 4'd8;
					default: wait_d = 4'd11;
				endcase
			end
			default: begin
				if (is_rom) begin
					// The offset is below 2^27, so adding the base only sets bit 27.
					mapped_d = {1'b1, rom_off};
					if (seq_s1) begin
						wait_d = n_two ? 4'd5 : 4'd2;
					end else begin
						wait_d = n_two ? 4'd9 : 4'd4;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			region_s2 <= region_s1;
			mapped_s2 <= mapped_d;
			off_s2    <= rom_off;
			is_rom_s2 <= is_rom;
			wait_s2   <= wait_d;
		end
	end

	// ---------------------------------------------------------------- stage 3
	logic                  valid_s3;
	region_t               region_s3;
	mapped_t               mapped_s3;
	logic                  oor_s3;
	logic [WAIT_W-1:0]     wait_s3;
	logic                  oor_d;

	// With a size of zero every offset compares as past the end.
	assign oor_d = is_rom_s2 && (off_s2 >= {1'b0, rom_size_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			region_s3 <= region_s2;
			mapped_s3 <= mapped_s2;
			oor_s3    <= oor_d;
			wait_s3   <= wait_s2;
		end
	end

	assign done             = valid_s3;
	assign region           = region_s3;
	assign mapped_address   = mapped_s3;
	assign rom_out_of_range = oor_s3;
	assign wait_cycles      = wait_s3;

	// ---------------------------------------------------------------- checks
	a_accept_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##2 done)
		else $error("accepted transaction did not reach the output after three cycles");

	a_oor_only_rom: assert property (@(posedge clk) disable iff (!arst_n)
		done && (region < REGION_ROM_LO || region > REGION_ROM_HI) |-> !rom_out_of_range)
		else $error("ROM range flag set outside the ROM regions");

	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> wait_cycles <= 4'd11)
		else $error("wait cycle count out of range");

	a_vram_fold: assert property (@(posedge clk) disable iff (!arst_n)
		done && region == REGION_VRAM |-> !(mapped_address[16] && mapped_address[15]))
		else $error("video RAM address not folded");

	a_rom_base: assert property (@(posedge clk) disable iff (!arst_n)
		done && region >= REGION_ROM_LO && region <= REGION_ROM_HI |-> mapped_address[27])
		else $error("ROM address lost its base");

endmodule
